@@ src/wmt_pkg.sv @@
package wmt_pkg;

  // Default geometry of the two windows and the byte store.
  localparam int unsigned STORE_BYTES_DEF      = 589824;
  localparam int unsigned FLASH_BYTES_DEF      = 524288;
  localparam int unsigned SRAM_BYTES_DEF       = 65536;
  localparam logic [31:0] FLASH_WINDOW_BASE_DEF = 32'h0000_0000;
  localparam logic [31:0] SRAM_WINDOW_BASE_DEF  = 32'h2000_0000;
  localparam int unsigned MAX_ACCESS_BYTES_DEF = 4;

  // Bus data width in bytes; one bank per byte lane.
  localparam int unsigned LANES = 4;

  // Command codes; every other code is an unsupported command.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;

  // Response status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ADDR_ERR = 2'd1;
  localparam logic [1:0] ST_CMD_ERR  = 2'd2;

endpackage

@@ src/windowed_memory_target_unit.sv @@
// The result strobe (done) is registered: an item taken passes the ACCESS and COLLECT states first.
// A new item is not taken before the last is through the decode, bank access and read-data
//   collect steps; start may be taken again in the cycle that carries the result.
// Reset: synchronous; a clearing pass then zeroes the store one bank row per cycle
//   up to the last row, with busy held high.
// The receiver cannot stall: each result is shown for exactly one cycle.
module windowed_memory_target_unit #(
  parameter int unsigned STORE_BYTES       = wmt_pkg::STORE_BYTES_DEF,
  parameter int unsigned FLASH_BYTES       = wmt_pkg::FLASH_BYTES_DEF,
  parameter int unsigned SRAM_BYTES        = wmt_pkg::SRAM_BYTES_DEF,
  parameter logic [31:0] FLASH_WINDOW_BASE = wmt_pkg::FLASH_WINDOW_BASE_DEF,
  parameter logic [31:0] SRAM_WINDOW_BASE  = wmt_pkg::SRAM_WINDOW_BASE_DEF,
  parameter int unsigned MAX_ACCESS_BYTES  = wmt_pkg::MAX_ACCESS_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] address,
  input  logic [2:0]  length,
  input  logic [31:0] write_data,
  input  logic        debug,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] read_data,
  output logic [2:0]  bytes_done
);
  import wmt_pkg::*;

  // The store is split into four byte banks: store offset o lives in bank o%4,
  // row o/4. An access of up to four bytes touches each bank at most once, so
  // an unaligned access still has all its banks read or written together in ACCESS.
  localparam int unsigned ROWS  = (STORE_BYTES + LANES - 1) / LANES;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned OFF_W = ROW_W + 2;

  // Window bounds, computed one bit wider so that the ends do not wrap.
  localparam logic [32:0] FLASH_LO  = {1'b0, FLASH_WINDOW_BASE};
  localparam logic [32:0] FLASH_HI  = FLASH_LO + 33'(FLASH_BYTES);
  localparam logic [32:0] SRAM_LO   = {1'b0, SRAM_WINDOW_BASE};
  localparam logic [32:0] SRAM_HI   = SRAM_LO + 33'(SRAM_BYTES);
  localparam logic [33:0] STORE_END = 34'(STORE_BYTES);
  localparam logic [2:0]  LEN_MAX   = 3'((MAX_ACCESS_BYTES > 4) ? 4 : MAX_ACCESS_BYTES);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  typedef enum logic [1:0] {
    CLEAR,    // zeroing the banks after reset
    IDLE,     // waiting for start
    ACCESS,   // banks read or written this cycle
    COLLECT   // bank read data valid; result formed
  } state_t;

  state_t state;
  logic [ROW_W-1:0] clr_row;

  // ---------------------------------------------------------------------------
  // Decode, straight off the input ports in the accept cycle
  // ---------------------------------------------------------------------------
  logic [32:0] addr_x;
  logic        flash_hit;
  logic        sram_hit;
  logic [33:0] off_wide;
  logic [33:0] end_wide;
  logic        map_ok;
  logic        len_ok;
  logic        cmd_other;
  logic [1:0]  status_dec;
  logic [OFF_W-1:0] off_dec;

  always_comb begin
    addr_x    = {1'b0, address};
    flash_hit = (addr_x >= FLASH_LO) && (addr_x < FLASH_HI);
    sram_hit  = (addr_x >= SRAM_LO) && (addr_x < SRAM_HI);
    // Flash is checked first, so it wins where the windows overlap.
    if (flash_hit) begin
      off_wide = {1'b0, addr_x - FLASH_LO};
    end else begin
      off_wide = 34'(FLASH_BYTES) + {1'b0, addr_x - SRAM_LO};
    end
    end_wide  = off_wide + 34'(length);
    map_ok    = (flash_hit || sram_hit) && (end_wide <= STORE_END);
    len_ok    = (length <= LEN_MAX);
    cmd_other = (cmd != CMD_READ) && (cmd != CMD_WRITE);
    off_dec   = off_wide[OFF_W-1:0];
    // Normal accesses check the command first; debug accesses never do.
    priority if (!debug && cmd_other) begin
      status_dec = ST_CMD_ERR;
    end else if (!len_ok || !map_ok) begin
      status_dec = ST_ADDR_ERR;
    end else begin
      status_dec = ST_OK;
    end
  end

  // Per-bank lane steering for the access
  logic [1:0]       lo_dec;
  logic [ROW_W-1:0] base_row_dec;
  logic [1:0]       lane_k   [LANES];
  logic             lane_en  [LANES];
  logic [ROW_W-1:0] lane_row [LANES];
  logic [7:0]       lane_wd  [LANES];

  always_comb begin
    lo_dec       = off_dec[1:0];
    base_row_dec = off_dec[OFF_W-1:2];
    for (int b = 0; b < LANES; b++) begin
      // byte index within the item that lands in bank b
      lane_k[b]   = 2'(b) - lo_dec;
      lane_en[b]  = ({1'b0, lane_k[b]} < length);
      // banks below the start lane take the next row
      lane_row[b] = base_row_dec + ROW_W'((2'(b) < lo_dec) ? 1 : 0);
      lane_wd[b]  = write_data[8*lane_k[b] +: 8];
    end
  end

  // ---------------------------------------------------------------------------
  // Registered item after decode
  // ---------------------------------------------------------------------------
  logic [1:0]       item_status;
  logic             item_read;
  logic             item_write;
  logic [2:0]       item_bytes;
  logic [1:0]       item_lo;
  logic             bank_en  [LANES];
  logic [ROW_W-1:0] bank_row [LANES];
  logic [7:0]       bank_wd  [LANES];

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_status <= status_dec;
      item_read   <= (status_dec == ST_OK) && (cmd == CMD_READ);
      item_write  <= (status_dec == ST_OK) && (cmd == CMD_WRITE);
      item_bytes  <= (status_dec == ST_OK) ? length : 3'd0;
      item_lo     <= lo_dec;
      for (int b = 0; b < LANES; b++) begin
        bank_en[b]  <= lane_en[b];
        bank_row[b] <= lane_row[b];
        bank_wd[b]  <= lane_wd[b];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte banks: one write or read port each, read data registered
  // ---------------------------------------------------------------------------
  logic             mem_we   [LANES];
  logic [ROW_W-1:0] mem_addr [LANES];
  logic [7:0]       mem_wd   [LANES];
  logic [7:0]       mem_q    [LANES];

  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      if (state == CLEAR) begin
        mem_we[b]   = 1'b1;
        mem_addr[b] = clr_row;
        mem_wd[b]   = 8'd0;
      end else begin
        mem_we[b]   = (state == ACCESS) && item_write && bank_en[b];
        mem_addr[b] = bank_row[b];
        mem_wd[b]   = bank_wd[b];
      end
    end
  end

  for (genvar gb = 0; gb < LANES; gb++) begin : g_bank
    logic [7:0] mem [ROWS];

    always_ff @(posedge clk) begin
      if (mem_we[gb]) begin
        mem[mem_addr[gb]] <= mem_wd[gb];
      end
      mem_q[gb] <= mem[mem_addr[gb]];
    end
  end

  // ---------------------------------------------------------------------------
  // Read data: rotate bank bytes back into item order, zero unused bytes
  // ---------------------------------------------------------------------------
  logic [31:0] rdata_col;
  logic [1:0]  col_bank [LANES];

  always_comb begin
    rdata_col = '0;
    for (int k = 0; k < LANES; k++) begin
      col_bank[k] = item_lo + 2'(k);
      if (item_read && (3'(k) < item_bytes)) begin
        rdata_col[8*k +: 8] = mem_q[col_bank[k]];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and registered result
  // ---------------------------------------------------------------------------
  assign busy = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= CLEAR;
      clr_row <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        CLEAR: begin
          if (clr_row == LAST_ROW) begin
            state <= IDLE;
          end
          clr_row <= clr_row + ROW_W'(1);
        end
        IDLE: begin
          if (start) begin
            state <= ACCESS;
          end
        end
        ACCESS: begin
          state <= COLLECT;
        end
        COLLECT: begin
          status     <= item_status;
          read_data  <= rdata_col;
          bytes_done <= item_bytes;
          done       <= 1'b1;
          state      <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ sim/tb_windowed_memory_target_unit.sv @@
`timescale 1ns / 1ps

module tb_windowed_memory_target_unit;

  // Window geometry, taken from the package defaults the DUT is built with.
  localparam logic [31:0] FLASH_ORIGIN = wmt_pkg::FLASH_WINDOW_BASE_DEF;
  localparam logic [31:0] SRAM_ORIGIN  = wmt_pkg::SRAM_WINDOW_BASE_DEF;
  localparam int unsigned FLASH_BYTES  = wmt_pkg::FLASH_BYTES_DEF;
  localparam int unsigned SRAM_BYTES   = wmt_pkg::SRAM_BYTES_DEF;

  // Command codes that are neither read nor write.
  localparam logic [1:0] CMD_OTHER = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Random part: phases of accesses, each closed by a full drain.
  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 100;

  // The clearing pass after reset keeps busy high with nothing accepted, so the stall
  // limit is sized from the bank row count (STORE_BYTES/LANES) to sit well above it.
  localparam int unsigned STALL_LIMIT =
    3 * (wmt_pkg::STORE_BYTES_DEF / wmt_pkg::LANES) + 1000;
  // Spare cycles waited at the end, after the last drain.
  localparam int unsigned TAIL_CYCLES = 6;

  // Shadow of the byte store plus the queue of access results still owed by the DUT.
  class mem_scoreboard;
    typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_data;
      logic [2:0]  bytes_done;
    } access_result_t;

    localparam longint unsigned FLASH_LO   = wmt_pkg::FLASH_WINDOW_BASE_DEF;
    localparam longint unsigned SRAM_LO    = wmt_pkg::SRAM_WINDOW_BASE_DEF;
    localparam longint unsigned FLASH_SPAN = wmt_pkg::FLASH_BYTES_DEF;
    localparam longint unsigned SRAM_SPAN  = wmt_pkg::SRAM_BYTES_DEF;
    localparam longint unsigned STORE_SIZE = wmt_pkg::STORE_BYTES_DEF;
    localparam int unsigned LEN_CAP =
      (wmt_pkg::MAX_ACCESS_BYTES_DEF > wmt_pkg::LANES) ? wmt_pkg::LANES
                                                       : wmt_pkg::MAX_ACCESS_BYTES_DEF;

    bit [7:0]       store_bytes [int unsigned];  // unwritten bytes read as zero
    access_result_t due_results [$];
    int unsigned    mismatches;
    int unsigned    results_seen;

    // Flash decodes first; the access must also fit inside the store.
    function bit map_window(logic [31:0] addr, logic [2:0] len, output int unsigned off);
      longint unsigned a;
      longint unsigned o;
      a = 64'(addr);
      if (a >= FLASH_LO && a < FLASH_LO + FLASH_SPAN) begin
        o = a - FLASH_LO;
      end else if (a >= SRAM_LO && a < SRAM_LO + SRAM_SPAN) begin
        o = FLASH_SPAN + (a - SRAM_LO);
      end else begin
        return 1'b0;
      end
      if (o + len > STORE_SIZE) return 1'b0;
      off = 32'(o);
      return 1'b1;
    endfunction

    // Work out the result of an accepted access and apply it to the shadow store.
    function void note_access(logic [1:0] op, logic [31:0] addr, logic [2:0] len,
                              logic [31:0] wdata, logic dbg);
      access_result_t r;
      int unsigned    off;
      bit             mapped;
      r = '0;
      off = 0;
      mapped = map_window(addr, len, off);
      if (!dbg && op != wmt_pkg::CMD_READ && op != wmt_pkg::CMD_WRITE) begin
        r.status = wmt_pkg::ST_CMD_ERR;
      end else if (len > LEN_CAP || !mapped) begin
        r.status = wmt_pkg::ST_ADDR_ERR;
      end else begin
        r.status = wmt_pkg::ST_OK;
        for (int i = 0; i < len; i++) begin
          if (op == wmt_pkg::CMD_READ) begin
            if (store_bytes.exists(off + i)) r.read_data[8*i +: 8] = store_bytes[off + i];
          end else if (op == wmt_pkg::CMD_WRITE) begin
            store_bytes[off + i] = wdata[8*i +: 8];
          end
        end
        // debug with another command moves nothing but still reports the length
        r.bytes_done = len;
      end
      due_results = {due_results, r};
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 60) $display("ERROR: result %0d: %s", results_seen, msg);
    endtask

    task check_result(logic [1:0] st, logic [31:0] rd, logic [2:0] nb);
      access_result_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result status=%0d read_data=%h bytes_done=%0d",
                         st, rd, nb));
        return;
      end
      want = due_results.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, want %0d", st, want.status));
      if (rd !== want.read_data)
        report($sformatf("read_data %h, want %h", rd, want.read_data));
      if (nb !== want.bytes_done)
        report($sformatf("bytes_done %0d, want %0d", nb, want.bytes_done));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd = wmt_pkg::CMD_READ;
  logic [31:0] address = '0;
  logic [2:0]  length = '0;
  logic [31:0] write_data = '0;
  logic        debug = 1'b0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] read_data;
  logic [2:0]  bytes_done;

  mem_scoreboard sb = new();

  bit          gaps_on = 1'b0;   // sender idles between items when set
  int unsigned stall_cycles = 0;

  windowed_memory_target_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .address    (address),
    .length     (length),
    .write_data (write_data),
    .debug      (debug),
    .done       (done),
    .status     (status),
    .read_data  (read_data),
    .bytes_done (bytes_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitor: everything sampled at the rising edge, i.e. values of the cycle that ends there.
  // The result is checked before the new item is noted; a result can never belong to an
  // item taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, read_data, bytes_done);
      if (start && !busy) sb.note_access(cmd, address, length, write_data, debug);
    end
  end

  // Watchdog: cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Sender idle time: mostly none or short, now and then long. Start is only lowered
  // when a real gap follows, so back-to-back items keep it high.
  task automatic idle_gap();
    int unsigned roll;
    int unsigned n;
    if (!gaps_on) return;
    roll = $urandom_range(0, 99);
    if (roll < 55) n = 0;
    else if (roll < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Present one access and hold it until the DUT takes it.
  task automatic send_access(logic [1:0] c, logic [31:0] a, logic [2:0] len,
                             logic [31:0] wd, logic dbg);
    start      <= 1'b1;
    cmd        <= c;
    address    <= a;
    length     <= len;
    write_data <= wd;
    debug      <= dbg;
    do @(posedge clk); while (busy !== 1'b0);
    idle_gap();
  endtask

  // Pause the sender until every owed result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  // Addresses cluster at window edges so writes get read back; a share is fully random.
  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    int unsigned r;
    r = $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0, 1, 2: a = FLASH_ORIGIN + $urandom_range(0, 63);
      3:       a = FLASH_ORIGIN + FLASH_BYTES - 1 - $urandom_range(0, 31);
      4, 5:    a = SRAM_ORIGIN + $urandom_range(0, 63);
      6:       a = SRAM_ORIGIN + SRAM_BYTES - 1 - $urandom_range(0, 31);
      7: begin
        // just outside a window
        case ($urandom_range(0, 2))
          0:       a = FLASH_ORIGIN + FLASH_BYTES + r;
          1:       a = SRAM_ORIGIN - 1 - r;
          default: a = SRAM_ORIGIN + SRAM_BYTES + r;
        endcase
      end
      8:       a = FLASH_ORIGIN + $urandom_range(0, FLASH_BYTES - 1);
      default: a = $urandom;
    endcase
    return a;
  endfunction

  task automatic send_random();
    logic [1:0]  c;
    logic [2:0]  len;
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) c = CMD_OTHER;
    else if (roll == 1) c = CMD_SPARE;
    else if (roll < 9) c = wmt_pkg::CMD_READ;
    else c = wmt_pkg::CMD_WRITE;
    roll = $urandom_range(0, 19);
    if (roll == 0) len = 3'd0;
    else if (roll == 1) len = 3'($urandom_range(5, 7));   // beyond the bus width
    else len = 3'($urandom_range(1, 4));
    send_access(c, pick_address(), len, $urandom, $urandom_range(0, 7) == 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, back to back. The first item waits out the clearing pass.
    send_access(wmt_pkg::CMD_READ,  FLASH_ORIGIN, 3'd4, 32'h0, 1'b0);   // cleared store
    send_access(wmt_pkg::CMD_WRITE, FLASH_ORIGIN, 3'd4, 32'h8765_4321, 1'b0);
    send_access(wmt_pkg::CMD_READ,  FLASH_ORIGIN, 3'd4, 32'h0, 1'b0);
    send_access(wmt_pkg::CMD_READ,  FLASH_ORIGIN + 1, 3'd2, 32'hFFFF_FFFF, 1'b0);
    // last flash byte: the write runs on into the SRAM part of the store
    send_access(wmt_pkg::CMD_WRITE, FLASH_ORIGIN + FLASH_BYTES - 1, 3'd4, 32'hFFFF_FFFF,
                1'b0);
    send_access(wmt_pkg::CMD_READ,  SRAM_ORIGIN, 3'd4, 32'h0, 1'b0);
    // top of SRAM, and one byte too far
    send_access(wmt_pkg::CMD_WRITE, SRAM_ORIGIN + SRAM_BYTES - 4, 3'd4, 32'hDEAD_BEEF, 1'b0);
    send_access(wmt_pkg::CMD_READ,  SRAM_ORIGIN + SRAM_BYTES - 4, 3'd4, 32'h0, 1'b0);
    send_access(wmt_pkg::CMD_WRITE, SRAM_ORIGIN + SRAM_BYTES - 3, 3'd4, 32'h1234_5678, 1'b0);
    send_access(wmt_pkg::CMD_READ,  SRAM_ORIGIN + SRAM_BYTES - 1, 3'd1, 32'h0, 1'b0);
    // unmapped addresses around the windows
    send_access(wmt_pkg::CMD_READ,  FLASH_ORIGIN + FLASH_BYTES, 3'd1, 32'h0, 1'b0);
    send_access(wmt_pkg::CMD_READ,  SRAM_ORIGIN - 1, 3'd1, 32'h0, 1'b0);
    send_access(wmt_pkg::CMD_READ,  SRAM_ORIGIN + SRAM_BYTES, 3'd1, 32'h0, 1'b0);
    send_access(wmt_pkg::CMD_WRITE, 32'hFFFF_FFFF, 3'd1, 32'hFFFF_FFFF, 1'b0);
    // other commands: command error wins over address decode unless debug
    send_access(CMD_OTHER, FLASH_ORIGIN + 4, 3'd2, 32'h0, 1'b0);
    send_access(CMD_SPARE, 32'hFFFF_FFFF, 3'd4, 32'h0, 1'b0);
    send_access(CMD_OTHER, FLASH_ORIGIN + 4, 3'd3, 32'h0, 1'b1);
    send_access(CMD_SPARE, 32'hFFFF_FFFF, 3'd4, 32'h0, 1'b1);
    send_access(wmt_pkg::CMD_WRITE, FLASH_ORIGIN + 8, 3'd4, 32'hCAFE_F00D, 1'b1);
    send_access(wmt_pkg::CMD_READ,  FLASH_ORIGIN + 8, 3'd4, 32'h0, 1'b1);
    // zero length moves nothing, but still needs a mapped address
    send_access(wmt_pkg::CMD_READ,  FLASH_ORIGIN + 8, 3'd0, 32'h0, 1'b0);
    send_access(wmt_pkg::CMD_WRITE, FLASH_ORIGIN + 8, 3'd0, 32'h0, 1'b0);
    send_access(wmt_pkg::CMD_READ,  SRAM_ORIGIN + SRAM_BYTES, 3'd0, 32'h0, 1'b0);
    // lengths past the bus width
    send_access(wmt_pkg::CMD_WRITE, FLASH_ORIGIN + 8, 3'd7, 32'hFFFF_FFFF, 1'b0);
    send_access(CMD_OTHER, FLASH_ORIGIN + 8, 3'd5, 32'h0, 1'b1);
    wait_drained();

    // Random part: first phase without gaps, second with, the rest chosen at random.
    // Every phase ends by holding off the sender until all results are back.
    for (int p = 0; p < PHASES; p++) begin
      gaps_on = (p == 1) || (p > 1 && $urandom_range(0, 2) != 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_random();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
